// ===== design/dncd_pkg.sv =====
package dncd_pkg;

   // port field widths
   localparam int DayW     = 30;
   localparam int YearW    = 21;
   localparam int MonthW   = 4;
   localparam int DomW     = 5;
   localparam int WeekdayW = 3;

   // internal widths
   localparam int ZW      = 31;  // biased day count, always positive
   localparam int EraW    = 13;  // biased era index
   localparam int DoeW    = 18;  // day of era, 0..146096
   localparam int YoeW    = 9;   // year of era, 0..399
   localparam int DoyW    = 9;   // day of March-based year, 0..365
   localparam int MpW     = 4;   // March-based month, 0..11
   localparam int YbW     = 23;  // signed astronomical year
   localparam int SpanW   = 11;  // 5 * doy + 2

   // calendar constants
   localparam int DaysToMar0000 = 719468;
   localparam int DaysPerEra    = 146097;
   localparam int LastDoe       = 146096;
   localparam int DaysPer4Yr    = 1460;
   localparam int DaysPerCent   = 36524;
   localparam int DaysPerYear   = 365;
   localparam int MonthSpan     = 153;
   localparam int MonthScale    = 5;
   localparam int MonthRound    = 2;
   localparam int YearsPerEra   = 400;
   localparam int MonthsPerYear = 12;
   localparam int MarchOffset   = 3;   // March-based month to January-based
   localparam int JanuaryMp     = 10;  // March-based index of January
   localparam int February      = 2;
   localparam int DaysPerWeek   = 7;
   localparam int WeekdayBias   = 3;   // (doe + 3) mod 7 is the weekday

   // Bias the day count by whole eras so the era division sees only positive values.
   // 146097 is a multiple of 7, so the bias leaves the weekday alone.
   localparam int EraBias  = 3680;
   localparam int ZBias    = DaysToMar0000 + EraBias * DaysPerEra;
   localparam int YearBias = EraBias * YearsPerEra;

   localparam int NumStages = 7;

   // Exact floor division by constants: multiply by ceil(2^S / D) and shift by S,
   // with 2^S larger than (largest dividend) * D.
   localparam int EraShift   = 49;
   localparam logic [31:0] EraRecip =
      32'(((64'd1 << EraShift) + 64'(DaysPerEra) - 64'd1) / 64'(DaysPerEra));

   localparam int Div4YrShift = 29;
   localparam logic [18:0] Div4YrRecip =
      19'(((64'd1 << Div4YrShift) + 64'(DaysPer4Yr) - 64'd1) / 64'(DaysPer4Yr));

   localparam int DivCentShift = 34;
   localparam logic [18:0] DivCentRecip =
      19'(((64'd1 << DivCentShift) + 64'(DaysPerCent) - 64'd1) / 64'(DaysPerCent));

   localparam int DivYearShift = 27;
   localparam logic [18:0] DivYearRecip =
      19'(((64'd1 << DivYearShift) + 64'(DaysPerYear) - 64'd1) / 64'(DaysPerYear));

   localparam int Div100Shift = 16;
   localparam logic [9:0] Div100Recip =
      10'(((64'd1 << Div100Shift) + 64'd99) / 64'd100);

   localparam int DivSpanShift = 19;
   localparam logic [11:0] DivSpanRecip =
      12'(((64'd1 << DivSpanShift) + 64'(MonthSpan) - 64'd1) / 64'(MonthSpan));

   function automatic logic [EraW-1:0] era_div(input logic [ZW-1:0] n);
      logic [62:0] p;
      p = 63'(n) * 63'(EraRecip);
      return p[EraShift+EraW-1:EraShift];
   endfunction

   function automatic logic [6:0] div_4yr(input logic [DoeW-1:0] n);
      logic [36:0] p;
      p = 37'(n) * 37'(Div4YrRecip);
      return p[Div4YrShift+6:Div4YrShift];
   endfunction

   function automatic logic [2:0] div_cent(input logic [DoeW-1:0] n);
      logic [36:0] p;
      p = 37'(n) * 37'(DivCentRecip);
      return p[DivCentShift+2:DivCentShift];
   endfunction

   function automatic logic [YoeW-1:0] div_year(input logic [DoeW-1:0] n);
      logic [36:0] p;
      p = 37'(n) * 37'(DivYearRecip);
      return p[DivYearShift+YoeW-1:DivYearShift];
   endfunction

   function automatic logic [1:0] div_100(input logic [YoeW-1:0] n);
      logic [18:0] p;
      p = 19'(n) * 19'(Div100Recip);
      return p[Div100Shift+1:Div100Shift];
   endfunction

   function automatic logic [MpW-1:0] div_span(input logic [SpanW-1:0] n);
      logic [22:0] p;
      p = 23'(n) * 23'(DivSpanRecip);
      return p[DivSpanShift+MpW-1:DivSpanShift];
   endfunction

   // first day of each March-based month within the March-based year
   function automatic logic [DoyW-1:0] month_start(input logic [MpW-1:0] mp);
      logic [DoyW-1:0] s;
      unique case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== design/dncd_weekday.sv =====
// Weekday from day of era: (doe + 3) mod 7, folded on octal digits since 8 = 1 mod 7.
module dncd_weekday (
   input  logic [dncd_pkg::DoeW-1:0]     doe,
   output logic [dncd_pkg::WeekdayW-1:0] weekday
);

   logic [dncd_pkg::DoeW-1:0] biased;
   logic [5:0]                fold1;
   logic [3:0]                fold2;

   always_comb begin
      biased = doe + dncd_pkg::DoeW'(dncd_pkg::WeekdayBias);
      fold1  = '0;
      for (int i = 0; i < dncd_pkg::DoeW / 3; i++) begin
         fold1 = fold1 + 6'(biased[3*i +: 3]);
      end
      fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
      // fold2 is at most 11, one subtract finishes the reduction
      if (fold2 >= 4'(dncd_pkg::DaysPerWeek)) begin
         weekday = 3'(fold2 - 4'(dncd_pkg::DaysPerWeek));
      end else begin
         weekday = fold2[2:0];
      end
   end

endmodule

// ===== design/dncd_month_split.sv =====
// Split a March-based day of year into March-based month and day of month.
module dncd_month_split (
   input  logic [dncd_pkg::DoyW-1:0] doy,
   output logic [dncd_pkg::MpW-1:0]  mp,
   output logic [dncd_pkg::DomW-1:0] day_of_month
);

   logic [dncd_pkg::SpanW-1:0] span;
   logic [dncd_pkg::DoyW-1:0]  offset;

   always_comb begin
      span   = dncd_pkg::SpanW'(doy) * dncd_pkg::SpanW'(dncd_pkg::MonthScale)
               + dncd_pkg::SpanW'(dncd_pkg::MonthRound);
      mp     = dncd_pkg::div_span(span);
      offset = doy - dncd_pkg::month_start(mp) + 9'd1;
      day_of_month = offset[dncd_pkg::DomW-1:0];
   end

endmodule

// ===== design/day_number_to_civil_date.sv =====
// Converts a signed day count (day 0 = 1970-01-01, 30-bit two's complement) into the
// proleptic Gregorian date and weekday. Years at or before astronomical year 0 come
// out as BC (rsp_era_flag = 0) with year 1 - y, so there is no year zero; weekday 0 is
// Sunday. Every 30-bit input gives a valid date, no saturation. The block is a
// seven-stage pipeline behind an output register that every transfer on req passes
// through to rsp; one transfer per cycle is sustained while rsp is not stalled.
// Each stage advances whenever the stage after it is empty or moving, so bubbles fill
// up under a stalled output and req_stall only rises once every stage holds an item.
// The stages follow the era method: bias and era division (one 31x32 multiply),
// day-of-era remainder, century/leap corrections, year of era, day of year, month split,
// and finally the month, year and era fix-up into the output register.
module day_number_to_civil_date (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [dncd_pkg::DayW-1:0] req_day_number,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_era_flag,
   output logic [dncd_pkg::YearW-1:0]     rsp_year_in_era,
   output logic [dncd_pkg::MonthW-1:0]    rsp_month_number,
   output logic [dncd_pkg::DomW-1:0]      rsp_day_of_month,
   output logic [dncd_pkg::WeekdayW-1:0]  rsp_weekday
);

   localparam int NS = dncd_pkg::NumStages;

   // pipeline control
   logic [NS-1:0] stage_valid_ff, stage_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NS:0]   ready;

   // stage 0: captured input
   logic signed [dncd_pkg::DayW-1:0] day0_ff;

   // stage 1: biased day count and era
   logic [dncd_pkg::ZW-1:0]   z1_ff, z1_in;
   logic [dncd_pkg::EraW-1:0] era1_ff, era1_in;
   logic signed [31:0]        z_sum;

   // stage 2: day of era
   logic [dncd_pkg::DoeW-1:0] doe2_ff, doe2_in;
   logic [dncd_pkg::EraW-1:0] era2_ff;
   logic [dncd_pkg::ZW-1:0]   era_days;
   logic [dncd_pkg::ZW-1:0]   doe_full;

   // stage 3: leap-corrected day of era, weekday
   logic [dncd_pkg::DoeW-1:0]     t3_ff, t3_in;
   logic [dncd_pkg::DoeW-1:0]     doe3_ff;
   logic [dncd_pkg::EraW-1:0]     era3_ff;
   logic [dncd_pkg::WeekdayW-1:0] wd3_ff, wd3_in;

   // stage 4: year of era
   logic [dncd_pkg::YoeW-1:0]     yoe4_ff, yoe4_in;
   logic [dncd_pkg::DoeW-1:0]     doe4_ff;
   logic [dncd_pkg::EraW-1:0]     era4_ff;
   logic [dncd_pkg::WeekdayW-1:0] wd4_ff;

   // stage 5: day of year and base year
   logic [dncd_pkg::DoyW-1:0]        doy5_ff, doy5_in;
   logic signed [dncd_pkg::YbW-1:0]  yb5_ff, yb5_in;
   logic [dncd_pkg::WeekdayW-1:0]    wd5_ff;
   logic [dncd_pkg::DoeW-1:0]        year_days;

   // stage 6: March-based month and day of month
   logic [dncd_pkg::MpW-1:0]         mp6_ff, mp6_in;
   logic [dncd_pkg::DomW-1:0]        dom6_ff, dom6_in;
   logic signed [dncd_pkg::YbW-1:0]  yb6_ff;
   logic [dncd_pkg::WeekdayW-1:0]    wd6_ff;

   // output register
   logic                             era_ff, era_in;
   logic [dncd_pkg::YearW-1:0]       year_ff, year_in;
   logic [dncd_pkg::MonthW-1:0]      month_ff, month_in;
   logic [dncd_pkg::DomW-1:0]        dom_ff;
   logic [dncd_pkg::WeekdayW-1:0]    wd_ff;
   logic                             jan_feb;
   logic signed [dncd_pkg::YbW-1:0]  astro_year;
   logic signed [dncd_pkg::YbW-1:0]  bc_year;

   // ---------------- pipeline control ----------------
   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      ready[NS] = !rsp_valid_ff || !rsp_stall;
      for (int k = NS - 1; k >= 0; k--) begin
         ready[k] = !stage_valid_ff[k] || ready[k+1];
      end
      stage_valid_in[0] = ready[0] ? req_valid : stage_valid_ff[0];
      for (int k = 1; k < NS; k++) begin
         stage_valid_in[k] = ready[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
      rsp_valid_in = ready[NS] ? stage_valid_ff[NS-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_stall = !ready[0];

   // ---------------- datapath ----------------
   // stage 0 -> 1: bias by whole eras, then divide by the era length
   always_comb begin
      z_sum   = 32'(day0_ff) + 32'(dncd_pkg::ZBias);
      z1_in   = z_sum[dncd_pkg::ZW-1:0];
      era1_in = dncd_pkg::era_div(z1_in);
   end

   // stage 1 -> 2: remainder within the era
   always_comb begin
      era_days = dncd_pkg::ZW'(era1_ff) * dncd_pkg::ZW'(dncd_pkg::DaysPerEra);
      doe_full = z1_ff - era_days;
      doe2_in  = doe_full[dncd_pkg::DoeW-1:0];
   end

   // stage 2 -> 3: drop leap days so that a plain divide by 365 gives the year
   always_comb begin
      t3_in = doe2_ff
              - dncd_pkg::DoeW'(dncd_pkg::div_4yr(doe2_ff))
              + dncd_pkg::DoeW'(dncd_pkg::div_cent(doe2_ff))
              - dncd_pkg::DoeW'(doe2_ff == dncd_pkg::DoeW'(dncd_pkg::LastDoe));
   end

   dncd_weekday u_weekday (
      .doe     (doe2_ff),
      .weekday (wd3_in)
   );

   // stage 3 -> 4: year of era
   assign yoe4_in = dncd_pkg::div_year(t3_ff);

   // stage 4 -> 5: day of the March-based year, and the astronomical base year
   always_comb begin
      year_days = dncd_pkg::DoeW'(yoe4_ff) * dncd_pkg::DoeW'(dncd_pkg::DaysPerYear)
                  + dncd_pkg::DoeW'(yoe4_ff >> 2)
                  - dncd_pkg::DoeW'(dncd_pkg::div_100(yoe4_ff));
      doy5_in = dncd_pkg::DoyW'(doe4_ff - year_days);
      yb5_in  = dncd_pkg::YbW'(yoe4_ff)
                + dncd_pkg::YbW'(era4_ff) * dncd_pkg::YbW'(dncd_pkg::YearsPerEra)
                - dncd_pkg::YbW'(dncd_pkg::YearBias);
   end

   // stage 5 -> 6: month split
   dncd_month_split u_month_split (
      .doy          (doy5_ff),
      .mp           (mp6_in),
      .day_of_month (dom6_in)
   );

   // stage 6 -> output: January and February belong to the next year; fold
   // non-positive years into the BC era
   always_comb begin
      jan_feb = mp6_ff >= dncd_pkg::MpW'(dncd_pkg::JanuaryMp);
      if (jan_feb) begin
         month_in = mp6_ff - dncd_pkg::MpW'(dncd_pkg::MonthsPerYear - dncd_pkg::MarchOffset);
      end else begin
         month_in = mp6_ff + dncd_pkg::MpW'(dncd_pkg::MarchOffset);
      end
      astro_year = yb6_ff + dncd_pkg::YbW'(jan_feb);
      bc_year    = dncd_pkg::YbW'(1) - astro_year;
      if (astro_year <= 0) begin
         era_in  = 1'b0;
         year_in = bc_year[dncd_pkg::YearW-1:0];
      end else begin
         era_in  = 1'b1;
         year_in = astro_year[dncd_pkg::YearW-1:0];
      end
   end

   // payload registers: load when the stage takes a new item, hold otherwise
   always_ff @(posedge clock) begin
      if (ready[0]) begin
         day0_ff <= req_day_number;
      end
      if (ready[1]) begin
         z1_ff   <= z1_in;
         era1_ff <= era1_in;
      end
      if (ready[2]) begin
         doe2_ff <= doe2_in;
         era2_ff <= era1_ff;
      end
      if (ready[3]) begin
         t3_ff   <= t3_in;
         doe3_ff <= doe2_ff;
         era3_ff <= era2_ff;
         wd3_ff  <= wd3_in;
      end
      if (ready[4]) begin
         yoe4_ff <= yoe4_in;
         doe4_ff <= doe3_ff;
         era4_ff <= era3_ff;
         wd4_ff  <= wd3_ff;
      end
      if (ready[5]) begin
         doy5_ff <= doy5_in;
         yb5_ff  <= yb5_in;
         wd5_ff  <= wd4_ff;
      end
      if (ready[6]) begin
         mp6_ff  <= mp6_in;
         dom6_ff <= dom6_in;
         yb6_ff  <= yb5_ff;
         wd6_ff  <= wd5_ff;
      end
      if (ready[NS]) begin
         era_ff   <= era_in;
         year_ff  <= year_in;
         month_ff <= month_in;
         dom_ff   <= dom6_ff;
         wd_ff    <= wd6_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_era_flag     = era_ff;
   assign rsp_year_in_era  = year_ff;
   assign rsp_month_number = month_ff;
   assign rsp_day_of_month = dom_ff;
   assign rsp_weekday      = wd_ff;

   // ---------------- assertions ----------------
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&stage_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("pipeline full under stall but input still taken");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !stage_valid_ff[NS-1]) |=> !rsp_valid_ff)
      else $error("result repeated after its transfer");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_month_number >= 4'd1 &&
                        rsp_month_number <= dncd_pkg::MonthW'(dncd_pkg::MonthsPerYear)))
      else $error("month out of range");

   a_day_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_day_of_month != '0 &&
                        rsp_weekday < dncd_pkg::WeekdayW'(dncd_pkg::DaysPerWeek) &&
                        rsp_year_in_era != '0))
      else $error("day, weekday or year out of range");

   a_february: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_month_number == dncd_pkg::MonthW'(dncd_pkg::February))
      |-> rsp_day_of_month <= 5'd29)
      else $error("February day past 29");

endmodule
